// ===== rtl/core/h2r_pkg.sv =====
`default_nettype none

package h2r_pkg;

    localparam logic [9:0]  TURN_DEG    = 10'd360;
    localparam logic [9:0]  TURN_DEG2   = 10'd720;
    localparam logic [5:0]  SECTOR_DEG  = 6'd60;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [13:0] FRAC_SCALE  = 14'd15300;

    // Reciprocal of the fraction scale; the estimate it gives is at most one low.
    localparam int unsigned RECIP_SHIFT = 32;
    localparam logic [18:0] RECIP       = 19'((64'd1 << RECIP_SHIFT) / 64'(FRAC_SCALE));

    // Cycles from an accepted word to its result strobe.
    localparam int unsigned PIPE_LATENCY = 7;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } sector_t;

    typedef struct packed {
        logic       valid;
        sector_t    sector;
        logic [5:0] h60;
        logic [7:0] sat;
        logic [7:0] val;
    } sector_word_t;

    typedef struct packed {
        logic       valid;
        sector_t    sector;
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } chan_word_t;

    // Exact floor(x / 255) for any x below 65280, where the quotient fits in eight bits.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] acc;
        acc = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/h2r_sector.sv =====
`default_nettype none

module h2r_sector (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [9:0]            hue,
    input  wire logic [7:0]            saturation,
    input  wire logic [7:0]            brightness,
    output h2r_pkg::sector_word_t      word_out
);
    import h2r_pkg::*;

    logic       valid1_reg;
    logic [8:0] h_reg, h_next;
    logic [7:0] s1_reg, v1_reg;

    logic       valid2_reg;
    sector_t    sector_reg, sector_next;
    logic [5:0] h60_reg, h60_next;
    logic [7:0] s2_reg, v2_reg;

    logic [8:0] base;

    // Hue never exceeds 1023, so at most two turns are removed.
    always_comb
    begin
        if (hue >= TURN_DEG2)
            h_next = 9'(hue - TURN_DEG2);
        else if (hue >= TURN_DEG)
            h_next = 9'(hue - TURN_DEG);
        else
            h_next = hue[8:0];
    end

    always_comb
    begin
        if (h_reg >= 9'd300)
        begin
            sector_next = SEC_MAG_RED;
            base        = 9'd300;
        end
        else if (h_reg >= 9'd240)
        begin
            sector_next = SEC_BLU_MAG;
            base        = 9'd240;
        end
        else if (h_reg >= 9'd180)
        begin
            sector_next = SEC_CYN_BLU;
            base        = 9'd180;
        end
        else if (h_reg >= 9'd120)
        begin
            sector_next = SEC_GRN_CYN;
            base        = 9'd120;
        end
        else if (h_reg >= 9'(SECTOR_DEG))
        begin
            sector_next = SEC_YEL_GRN;
            base        = 9'(SECTOR_DEG);
        end
        else
        begin
            sector_next = SEC_RED_YEL;
            base        = 9'd0;
        end
        h60_next = 6'(h_reg - base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        s1_reg     <= saturation;
        v1_reg     <= brightness;
        sector_reg <= sector_next;
        h60_reg    <= h60_next;
        s2_reg     <= s1_reg;
        v2_reg     <= v1_reg;
    end

    assign word_out.valid  = valid2_reg;
    assign word_out.sector = sector_reg;
    assign word_out.h60    = h60_reg;
    assign word_out.sat    = s2_reg;
    assign word_out.val    = v2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/h2r_scale.sv =====
`default_nettype none

module h2r_scale (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire h2r_pkg::sector_word_t word_in,
    output h2r_pkg::chan_word_t        word_out
);
    import h2r_pkg::*;

    localparam int unsigned NUM_W  = 22;
    localparam int unsigned PROD_W = NUM_W + 19;

    // Stage A: products of saturation with the sector position, and of value with 255 minus saturation.
    logic        va_reg;
    sector_t     seca_reg;
    logic [7:0]  va_v_reg;
    logic [13:0] sh_reg, sh_next;
    logic [13:0] sl_reg, sl_next;
    logic [15:0] pnum_reg, pnum_next;

    // Stage B: numerators of q and t, p finished.
    logic            vb_reg;
    sector_t         secb_reg;
    logic [7:0]      vb_v_reg;
    logic [7:0]      pb_reg;
    logic [NUM_W-1:0] qn_reg, qn_next;
    logic [NUM_W-1:0] tn_reg, tn_next;

    // Stage C: reciprocal estimates.
    logic            vc_reg;
    sector_t         secc_reg;
    logic [7:0]      vc_v_reg;
    logic [7:0]      pc_reg;
    logic [NUM_W-1:0] qnc_reg, tnc_reg;
    logic [7:0]      qe_reg, qe_next;
    logic [7:0]      te_reg, te_next;
    logic [PROD_W-1:0] qprod, tprod;

    // Stage D: corrected quotients.
    logic            vd_reg;
    sector_t         secd_reg;
    logic [7:0]      vd_v_reg;
    logic [7:0]      pd_reg;
    logic [7:0]      q_reg, q_next;
    logic [7:0]      t_reg, t_next;
    logic [NUM_W-1:0] qrem, trem;

    always_comb
    begin
        sh_next   = 14'(word_in.sat * word_in.h60);
        sl_next   = 14'(word_in.sat * (SECTOR_DEG - word_in.h60));
        pnum_next = 16'(word_in.val * (FULL_SCALE - word_in.sat));
    end

    always_comb
    begin
        qn_next = NUM_W'(va_v_reg * (FRAC_SCALE - sh_reg));
        tn_next = NUM_W'(va_v_reg * (FRAC_SCALE - sl_reg));
    end

    always_comb
    begin
        qprod   = PROD_W'(qn_reg) * PROD_W'(RECIP);
        tprod   = PROD_W'(tn_reg) * PROD_W'(RECIP);
        qe_next = qprod[RECIP_SHIFT +: 8];
        te_next = tprod[RECIP_SHIFT +: 8];
    end

    always_comb
    begin
        qrem   = qnc_reg - NUM_W'(qe_reg * FRAC_SCALE);
        trem   = tnc_reg - NUM_W'(te_reg * FRAC_SCALE);
        q_next = (qrem >= NUM_W'(FRAC_SCALE)) ? 8'(qe_reg + 8'd1) : qe_reg;
        t_next = (trem >= NUM_W'(FRAC_SCALE)) ? 8'(te_reg + 8'd1) : te_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= word_in.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        seca_reg <= word_in.sector;
        va_v_reg <= word_in.val;
        sh_reg   <= sh_next;
        sl_reg   <= sl_next;
        pnum_reg <= pnum_next;

        secb_reg <= seca_reg;
        vb_v_reg <= va_v_reg;
        pb_reg   <= div255(pnum_reg);
        qn_reg   <= qn_next;
        tn_reg   <= tn_next;

        secc_reg <= secb_reg;
        vc_v_reg <= vb_v_reg;
        pc_reg   <= pb_reg;
        qnc_reg  <= qn_reg;
        tnc_reg  <= tn_reg;
        qe_reg   <= qe_next;
        te_reg   <= te_next;

        secd_reg <= secc_reg;
        vd_v_reg <= vc_v_reg;
        pd_reg   <= pc_reg;
        q_reg    <= q_next;
        t_reg    <= t_next;
    end

    assign word_out.valid  = vd_reg;
    assign word_out.sector = secd_reg;
    assign word_out.v      = vd_v_reg;
    assign word_out.p      = pd_reg;
    assign word_out.q      = q_reg;
    assign word_out.t      = t_reg;

endmodule

`default_nettype wire

// ===== rtl/core/h2r_pack.sv =====
`default_nettype none

module h2r_pack (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire h2r_pkg::chan_word_t   word_in,
    output logic                       done,
    output logic [15:0]                pixel
);
    import h2r_pkg::*;

    logic        done_reg;
    logic [15:0] pixel_reg, pixel_next;
    logic [7:0]  r, g, b;

    always_comb
    begin
        unique case (word_in.sector)
            SEC_RED_YEL: begin r = word_in.v; g = word_in.t; b = word_in.p; end
            SEC_YEL_GRN: begin r = word_in.q; g = word_in.v; b = word_in.p; end
            SEC_GRN_CYN: begin r = word_in.p; g = word_in.v; b = word_in.t; end
            SEC_CYN_BLU: begin r = word_in.p; g = word_in.q; b = word_in.v; end
            SEC_BLU_MAG: begin r = word_in.t; g = word_in.p; b = word_in.v; end
            SEC_MAG_RED: begin r = word_in.v; g = word_in.p; b = word_in.q; end
            default:     begin r = word_in.v; g = word_in.p; b = word_in.q; end
        endcase
        pixel_next = {r[7:3], g[7:2], b[7:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= word_in.valid;
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign done  = done_reg;
    assign pixel = pixel_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb565_top.sv =====
`default_nettype none

// HSV to RGB565 pixel converter. A word is taken on every clock edge at which
// start is high; busy is always low, so a new pixel may be offered each cycle
// and the sustained rate is one pixel per clock. Each pixel comes out on
// pixel with done high for a single cycle. The receiver cannot stall and
// must take every result when done is high. The pipeline has seven register
// stages: hue reduction, sector select, the saturation products, the value
// products with p finished, the reciprocal estimates for division by 15300,
// their one-step correction, and the channel routing and packing register.
module hsv_to_rgb565_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [9:0]  hue,
    input  wire logic [7:0]  saturation,
    input  wire logic [7:0]  brightness,
    output logic             done,
    output logic [15:0]      pixel
);
    import h2r_pkg::*;

    sector_word_t sec_word;
    chan_word_t   chan_word;

    assign busy = 1'b0;

    h2r_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .word_out   (sec_word)
    );

    h2r_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_in  (sec_word),
        .word_out (chan_word)
    );

    h2r_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_in (chan_word),
        .done    (done),
        .pixel   (pixel)
    );

endmodule

`default_nettype wire

// ===== rtl/core/h2r_checker.sv =====
`default_nettype none

module h2r_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [7:0]  saturation,
    input  wire logic [7:0]  brightness,
    input  wire logic        done,
    input  wire logic [15:0] pixel
);
    import h2r_pkg::*;

    // Every accepted word yields its pixel once it has passed through the pipeline.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted word produced no result");

    // No result appears without an accepted word that went through the pipeline before it.
    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result strobe without an accepted word");

    // Zero brightness is black whatever the hue and saturation.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && brightness == 8'd0) |-> ##PIPE_LATENCY (pixel == 16'h0000))
        else $error("zero brightness did not give black");

    // Zero saturation at full brightness is white.
    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && saturation == 8'd0 && brightness == 8'd255)
            |-> ##PIPE_LATENCY (pixel == 16'hFFFF))
        else $error("grey at full brightness did not give white");

endmodule

bind hsv_to_rgb565_top h2r_checker u_h2r_checker (.*);

`default_nettype wire
